// File: rtl/assert_macros.svh
// Assertion helpers for the depth deprojection block.
// The macros expect signals named clock and reset in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock edge, off during reset.
`define DPU_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Same-cycle implication.
`define DPU_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: rtl/dpu_pkg.sv
// ----------------------------------------------------------------------------
// dpu_pkg
// Shared types and constants of the depth-to-point deprojection block.
// ----------------------------------------------------------------------------
package dpu_pkg;

   localparam int MAX_DIM    = 4096;
   localparam int MAX_POINTS = 16777216;

   localparam int DIM_W    = 13;   // frame_width / frame_height registers
   localparam int POS_W    = 12;   // column / row counters
   localparam int PTS_W    = 25;   // point counts
   localparam int PP_W     = 20;   // principal point, Q12.8
   localparam int INV_W    = 25;   // reciprocal focal length, Q1.24
   localparam int RAW_W    = 16;
   localparam int COORD_W  = 32;
   localparam int DEPTH_W  = 40;   // depth in Q24.16 before saturation
   localparam int MUL_W    = 32;
   localparam int CSR_AW   = 5;
   localparam int CSR_DW   = 32;
   localparam int RSP_DW   = 128;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_FRAME_WIDTH    = 3'd0;
   localparam logic [2:0] REG_FRAME_HEIGHT   = 3'd1;
   localparam logic [2:0] REG_DEPTH_SCALE    = 3'd2;
   localparam logic [2:0] REG_PRINCIPAL_X    = 3'd3;
   localparam logic [2:0] REG_PRINCIPAL_Y    = 3'd4;
   localparam logic [2:0] REG_INV_FOCAL_X    = 3'd5;
   localparam logic [2:0] REG_INV_FOCAL_Y    = 3'd6;
   localparam logic [2:0] REG_POINT_CAPACITY = 3'd7;

   typedef struct packed {
      logic [DIM_W-1:0] frame_width;
      logic [DIM_W-1:0] frame_height;
      logic [31:0]      depth_scale;
      logic [PP_W-1:0]  principal_x;
      logic [PP_W-1:0]  principal_y;
      logic [INV_W-1:0] inv_focal_x;
      logic [INV_W-1:0] inv_focal_y;
      logic [PTS_W-1:0] point_capacity;
   } cfg_type;

   typedef struct packed {
      logic [MUL_W-1:0] op_a;
      logic [MUL_W-1:0] op_b;
   } mul_req_type;

endpackage

// File: rtl/dpu_csr.sv
// ----------------------------------------------------------------------------
// dpu_csr
// APB-style register file holding the camera intrinsics and frame setup.
// ----------------------------------------------------------------------------
module dpu_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [dpu_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [dpu_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [dpu_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready,
   output dpu_pkg::cfg_type            cfg
);

   dpu_pkg::cfg_type cfg_ff;
   dpu_pkg::cfg_type cfg_in;
   logic [2:0]       reg_idx;
   logic             wr_en;

   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            dpu_pkg::REG_FRAME_WIDTH:    cfg_in.frame_width    = csr_pwdata[12:0];
            dpu_pkg::REG_FRAME_HEIGHT:   cfg_in.frame_height   = csr_pwdata[12:0];
            dpu_pkg::REG_DEPTH_SCALE:    cfg_in.depth_scale    = csr_pwdata;
            dpu_pkg::REG_PRINCIPAL_X:    cfg_in.principal_x    = csr_pwdata[19:0];
            dpu_pkg::REG_PRINCIPAL_Y:    cfg_in.principal_y    = csr_pwdata[19:0];
            dpu_pkg::REG_INV_FOCAL_X:    cfg_in.inv_focal_x    = csr_pwdata[24:0];
            dpu_pkg::REG_INV_FOCAL_Y:    cfg_in.inv_focal_y    = csr_pwdata[24:0];
            dpu_pkg::REG_POINT_CAPACITY: cfg_in.point_capacity = csr_pwdata[24:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         dpu_pkg::REG_FRAME_WIDTH:    csr_prdata = {19'd0, cfg_ff.frame_width};
         dpu_pkg::REG_FRAME_HEIGHT:   csr_prdata = {19'd0, cfg_ff.frame_height};
         dpu_pkg::REG_DEPTH_SCALE:    csr_prdata = cfg_ff.depth_scale;
         dpu_pkg::REG_PRINCIPAL_X:    csr_prdata = {12'd0, cfg_ff.principal_x};
         dpu_pkg::REG_PRINCIPAL_Y:    csr_prdata = {12'd0, cfg_ff.principal_y};
         dpu_pkg::REG_INV_FOCAL_X:    csr_prdata = {7'd0, cfg_ff.inv_focal_x};
         dpu_pkg::REG_INV_FOCAL_Y:    csr_prdata = {7'd0, cfg_ff.inv_focal_y};
         dpu_pkg::REG_POINT_CAPACITY: csr_prdata = {7'd0, cfg_ff.point_capacity};
         default:                     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width    <= 13'd640;
         cfg_ff.frame_height   <= 13'd480;
         cfg_ff.depth_scale    <= 32'd16777;
         cfg_ff.principal_x    <= '0;
         cfg_ff.principal_y    <= '0;
         cfg_ff.inv_focal_x    <= 25'(dpu_pkg::MAX_POINTS);
         cfg_ff.inv_focal_y    <= 25'(dpu_pkg::MAX_POINTS);
         cfg_ff.point_capacity <= 25'(dpu_pkg::MAX_POINTS);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/dpu_mul.sv
// ----------------------------------------------------------------------------
// dpu_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module dpu_mul (
   input  logic                          clock,
   input  dpu_pkg::mul_req_type          mul_req,
   output logic [2*dpu_pkg::MUL_W-1:0]   mul_prod
);

   logic [2*dpu_pkg::MUL_W-1:0] prod_ff;
   logic [2*dpu_pkg::MUL_W-1:0] prod_in;

   assign prod_in  = {{dpu_pkg::MUL_W{1'b0}}, mul_req.op_a} *
                     {{dpu_pkg::MUL_W{1'b0}}, mul_req.op_b};
   assign mul_prod = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// File: rtl/dpu_seq.sv
// ----------------------------------------------------------------------------
// dpu_seq
// Sequencer: pixel position tracking, multi-word products on the shared
// multiplier, saturation, point counting and the result register.
// ----------------------------------------------------------------------------
module dpu_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  dpu_pkg::cfg_type              cfg,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [dpu_pkg::RAW_W-1:0]     req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [dpu_pkg::RSP_DW-1:0]    rsp_tdata,
   output logic                          rsp_tuser,
   output logic                          rsp_tlast,
   output dpu_pkg::mul_req_type          mul_req,
   input  logic [2*dpu_pkg::MUL_W-1:0]   mul_prod
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DEPTH = 3'd1;  // product holds raw * scale
   localparam logic [2:0] ST_AHI   = 3'd2;  // product holds depth_hi * offset
   localparam logic [2:0] ST_ALO   = 3'd3;  // product holds depth_lo * offset
   localparam logic [2:0] ST_MLO   = 3'd4;  // product holds a_lo * inv
   localparam logic [2:0] ST_MHI   = 3'd5;  // product holds a_hi * inv
   localparam logic [2:0] ST_DONE  = 3'd6;

   function automatic logic [dpu_pkg::DIM_W-1:0] clamp_dim(
      input logic [dpu_pkg::DIM_W-1:0] v);
      logic [dpu_pkg::DIM_W-1:0] r;
      if (v == '0)
         r = dpu_pkg::DIM_W'(1);
      else if (v > dpu_pkg::DIM_W'(dpu_pkg::MAX_DIM))
         r = dpu_pkg::DIM_W'(dpu_pkg::MAX_DIM);
      else
         r = v;
      return r;
   endfunction

   logic [2:0]                   state_ff, state_in;
   logic [dpu_pkg::POS_W-1:0]    col_ff, col_in;
   logic [dpu_pkg::POS_W-1:0]    row_ff, row_in;
   logic [dpu_pkg::PTS_W-1:0]    pts_ff, pts_in;
   logic                         row_end_ff, row_end_in;
   logic                         fend_ff, fend_in;
   logic                         cap_ok_ff, cap_ok_in;
   logic                         emit_ff, emit_in;
   logic                         axis_ff, axis_in;
   logic [dpu_pkg::PP_W-1:0]     off_x_ff, off_x_in;
   logic [dpu_pkg::PP_W-1:0]     off_y_ff, off_y_in;
   logic                         neg_x_ff, neg_x_in;
   logic                         neg_y_ff, neg_y_in;
   logic [dpu_pkg::DEPTH_W-1:0]  d_ff, d_in;
   logic [28:0]                  ahi_ff, ahi_in;
   logic [dpu_pkg::INV_W-1:0]    frac_ff, frac_in;
   logic [dpu_pkg::COORD_W-1:0]  x_ff, x_in;
   logic [dpu_pkg::COORD_W-1:0]  y_ff, y_in;
   logic                         out_valid_ff, out_valid_in;
   logic [dpu_pkg::RSP_DW-1:0]   out_data_ff, out_data_in;
   logic                         out_user_ff, out_user_in;
   logic                         out_last_ff, out_last_in;

   logic [dpu_pkg::DIM_W-1:0]    w_lim;
   logic [dpu_pkg::DIM_W-1:0]    h_lim;
   logic [dpu_pkg::PTS_W-1:0]    cap_lim;
   logic                         row_end_now;
   logic                         fend_now;
   logic [dpu_pkg::PP_W-1:0]     pix_x, pix_y;
   logic [dpu_pkg::PP_W-1:0]     off_sel;
   logic [dpu_pkg::INV_W-1:0]    inv_sel;
   logic                         neg_sel;
   logic [54:0]                  m_sum;
   logic [dpu_pkg::COORD_W-1:0]  coord_sat;
   logic [dpu_pkg::PTS_W-1:0]    pts_next;
   logic [dpu_pkg::COORD_W-1:0]  z_sat;
   logic                         accept;
   logic                         has_result;
   logic                         can_load;

   assign w_lim   = clamp_dim(cfg.frame_width);
   assign h_lim   = clamp_dim(cfg.frame_height);
   assign cap_lim = (cfg.point_capacity > dpu_pkg::PTS_W'(dpu_pkg::MAX_POINTS)) ?
                    dpu_pkg::PTS_W'(dpu_pkg::MAX_POINTS) : cfg.point_capacity;

   assign row_end_now = {1'b0, col_ff} >= (w_lim - dpu_pkg::DIM_W'(1));
   assign fend_now    = row_end_now && ({1'b0, row_ff} >= (h_lim - dpu_pkg::DIM_W'(1)));

   assign pix_x = {col_ff, 8'd0};
   assign pix_y = {row_ff, 8'd0};

   assign off_sel = axis_ff ? off_y_ff : off_x_ff;
   assign inv_sel = axis_ff ? cfg.inv_focal_y : cfg.inv_focal_x;
   assign neg_sel = axis_ff ? neg_y_ff : neg_x_ff;

   // floor(D*|off|*inv / 2^32) = a_hi*inv + floor(a_lo*inv / 2^32)
   assign m_sum = {1'b0, mul_prod[53:0]} + 55'(frac_ff);

   always_comb begin
      if (neg_sel)
         coord_sat = (m_sum >= 55'h8000_0000) ? 32'h8000_0000 : (32'd0 - m_sum[31:0]);
      else
         coord_sat = (m_sum > 55'h7FFF_FFFF) ? 32'h7FFF_FFFF : m_sum[31:0];
   end

   assign z_sat    = (d_ff[39:32] != 8'd0) ? 32'hFFFF_FFFF : d_ff[31:0];
   assign pts_next = emit_ff ? (pts_ff + dpu_pkg::PTS_W'(1)) : pts_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign has_result = emit_ff || fend_ff;
   assign can_load   = !out_valid_ff || rsp_tready;

   // operand select for the shared multiplier
   always_comb begin
      mul_req.op_a = '0;
      mul_req.op_b = '0;
      case (state_ff)
         ST_IDLE: begin
            mul_req.op_a = {16'd0, req_tdata};
            mul_req.op_b = cfg.depth_scale;
         end
         ST_DEPTH: begin
            mul_req.op_a = {24'd0, mul_prod[47:40]};
            mul_req.op_b = {12'd0, off_x_ff};
         end
         ST_AHI: begin
            mul_req.op_a = d_ff[31:0];
            mul_req.op_b = {12'd0, off_sel};
         end
         ST_ALO: begin
            mul_req.op_a = mul_prod[31:0];
            mul_req.op_b = {7'd0, inv_sel};
         end
         ST_MLO: begin
            mul_req.op_a = {3'd0, ahi_ff};
            mul_req.op_b = {7'd0, inv_sel};
         end
         ST_MHI: begin
            // start of the row axis; unused after it
            mul_req.op_a = {24'd0, d_ff[39:32]};
            mul_req.op_b = {12'd0, off_y_ff};
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      pts_in       = pts_ff;
      row_end_in   = row_end_ff;
      fend_in      = fend_ff;
      cap_ok_in    = cap_ok_ff;
      emit_in      = emit_ff;
      axis_in      = axis_ff;
      off_x_in     = off_x_ff;
      off_y_in     = off_y_ff;
      neg_x_in     = neg_x_ff;
      neg_y_in     = neg_y_ff;
      d_in         = d_ff;
      ahi_in       = ahi_ff;
      frac_in      = frac_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_user_in  = out_user_ff;
      out_last_in  = out_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               row_end_in = row_end_now;
               fend_in    = fend_now;
               cap_ok_in  = pts_ff < cap_lim;
               axis_in    = 1'b0;
               neg_x_in   = pix_x < cfg.principal_x;
               off_x_in   = (pix_x < cfg.principal_x) ? (cfg.principal_x - pix_x) :
                                                        (pix_x - cfg.principal_x);
               neg_y_in   = pix_y < cfg.principal_y;
               off_y_in   = (pix_y < cfg.principal_y) ? (cfg.principal_y - pix_y) :
                                                        (pix_y - cfg.principal_y);
               state_in   = ST_DEPTH;
            end
         end
         ST_DEPTH: begin
            d_in    = mul_prod[47:8];
            emit_in = cap_ok_ff && (mul_prod[47:0] != 48'd0);
            state_in = (cap_ok_ff && (mul_prod[47:0] != 48'd0)) ? ST_AHI : ST_DONE;
         end
         ST_AHI: begin
            ahi_in   = mul_prod[28:0];
            state_in = ST_ALO;
         end
         ST_ALO: begin
            ahi_in   = ahi_ff + {8'd0, mul_prod[52:32]};
            state_in = ST_MLO;
         end
         ST_MLO: begin
            frac_in  = mul_prod[56:32];
            state_in = ST_MHI;
         end
         ST_MHI: begin
            if (!axis_ff) begin
               x_in     = coord_sat;
               axis_in  = 1'b1;
               state_in = ST_AHI;
            end else begin
               y_in     = coord_sat;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!has_result || can_load) begin
               if (has_result) begin
                  out_valid_in = 1'b1;
                  out_data_in  = {7'd0, pts_next, z_sat,
                                  emit_ff ? y_ff : 32'd0,
                                  emit_ff ? x_ff : 32'd0};
                  out_user_in  = emit_ff;
                  out_last_in  = fend_ff;
               end
               if (fend_ff) begin
                  col_in = '0;
                  row_in = '0;
                  pts_in = '0;
               end else if (row_end_ff) begin
                  col_in = '0;
                  row_in = row_ff + dpu_pkg::POS_W'(1);
                  pts_in = pts_next;
               end else begin
                  col_in = col_ff + dpu_pkg::POS_W'(1);
                  pts_in = pts_next;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // z is zero on a frame-end-only result since the depth path never ran
   // with a point; force it so
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         pts_ff       <= '0;
         out_valid_ff <= 1'b0;
         emit_ff      <= 1'b0;
         fend_ff      <= 1'b0;
         axis_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         pts_ff       <= pts_in;
         out_valid_ff <= out_valid_in;
         emit_ff      <= emit_in;
         fend_ff      <= fend_in;
         axis_ff      <= axis_in;
      end
   end

   always_ff @(posedge clock) begin
      row_end_ff  <= row_end_in;
      cap_ok_ff   <= cap_ok_in;
      off_x_ff    <= off_x_in;
      off_y_ff    <= off_y_in;
      neg_x_ff    <= neg_x_in;
      neg_y_ff    <= neg_y_in;
      d_ff        <= (state_ff == ST_DEPTH && !emit_in) ? '0 : d_in;
      ahi_ff      <= ahi_in;
      frac_ff     <= frac_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      out_data_ff <= out_data_in;
      out_user_ff <= out_user_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// File: rtl/depth_to_point_unproject_top.sv
// ----------------------------------------------------------------------------
// depth_to_point_unproject_top
// Pinhole-camera deprojection of a row-major depth stream to 3D points.
// ----------------------------------------------------------------------------
// Usage:
//  req_* carries one raw 16-bit depth pixel per request, row-major; the block
//  tracks column and row itself from frame_width and frame_height.
//  rsp_* carries a point (x, y, z in Q16.16 metres, saturated) for each pixel
//  with nonzero depth while the frame's point capacity lasts, and always one
//  result on the last pixel of a frame (tlast) with the frame's point count.
//  Datapath: all products go through a single 32x32 multiplier, two partial
//  products per step, four per axis. A pixel that yields a point runs the
//  depth product, then the column axis and the row axis, and then loads the
//  result register; a skipped pixel, also a frame end without a point, goes
//  from the depth product straight to ST_DONE. The next request is taken
//  only once the block is idle again; req_tready is low while busy.
//  Results wait in an output register; a stalled rsp_tready holds the block
//  only when a new result is ready to go out, so pixels without a result pass
//  and the next result is formed during a stall. Reset restores the register
//  defaults and restarts the frame at row 0, column 0 with a point count of
//  zero. The user must write csr_* while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module depth_to_point_unproject_top (
   input  logic                         clock,
   input  logic                         reset,
   // request: [15:0] depth_raw
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [dpu_pkg::RAW_W-1:0]    req_tdata,
   // result: [31:0] point_x, [63:32] point_y, [95:64] point_z,
   //         [120:96] used_count, [127:121] zero
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [dpu_pkg::RSP_DW-1:0]   rsp_tdata,
   // [0] point_valid
   output logic                         rsp_tuser,
   output logic                         rsp_tlast,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [dpu_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [dpu_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [dpu_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready
);

   dpu_pkg::cfg_type                 cfg;
   dpu_pkg::mul_req_type             mul_req;
   logic [2*dpu_pkg::MUL_W-1:0]      mul_prod;

   dpu_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dpu_mul u_mul (
      .clock    (clock),
      .mul_req  (mul_req),
      .mul_prod (mul_prod)
   );

   dpu_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .mul_req    (mul_req),
      .mul_prod   (mul_prod)
   );

   `DPU_ASSERT(a_busy_after_accept, (req_tvalid && req_tready) |=> !req_tready, "request taken while busy")
   `DPU_ASSERT_IMPL(a_empty_is_frame_end, rsp_tvalid && !rsp_tuser, rsp_tlast, "pointless result not at frame end")
   `DPU_ASSERT_IMPL(a_empty_is_zero, rsp_tvalid && !rsp_tuser, rsp_tdata[95:0] == 96'd0, "pointless result has nonzero coordinates")
   `DPU_ASSERT_IMPL(a_point_counted, rsp_tvalid && rsp_tuser, rsp_tdata[120:96] != 25'd0, "point result with zero count")

endmodule
